FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the race detector.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/iwrd_pkg.sv
// Shared constants for the inflight write race detector.
// No dependencies; imported by inflight_write_race_detector_core.
package iwrd_pkg;

    localparam int MODE_W   = 2;
    localparam int CPU_ID_W = 2;
    localparam int ORDER_W  = 3;

    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [CPU_ID_W-1:0] cpu_id_t;
    typedef logic [ORDER_W-1:0] order_t;

    localparam mode_t MODE_READ        = 2'd0;
    localparam mode_t MODE_WRITE_BEGIN = 2'd1;
    localparam mode_t MODE_WRITE_END   = 2'd2;
    localparam mode_t MODE_FENCE       = 2'd3;

    localparam order_t ORD_RELAXED = 3'd0;
    localparam order_t ORD_CONSUME = 3'd1;
    localparam order_t ORD_ACQUIRE = 3'd2;
    localparam order_t ORD_RELEASE = 3'd3;
    localparam order_t ORD_ACQ_REL = 3'd4;
    localparam order_t ORD_SEQ_CST = 3'd5;

    // Only release-type orderings empty a CPU's history.
    function automatic logic is_release(input order_t ord);
        return (ord == ORD_RELEASE) || (ord == ORD_ACQ_REL) || (ord == ORD_SEQ_CST);
    endfunction

endpackage

FILE: sv/inflight_write_race_detector_core.sv
// An event is taken into the input register, and its result then into the result
// register. Throughput: one event per cycle, sustained while m_axis_tready is high.
// The all-entry compare sits between the two registers and the history updates as
// each event moves on, so each event sees the history left by the one before it.
// Reset (aresetn low, synchronous) empties every history and drops both stages.
`include "assert_macros.svh"

module inflight_write_race_detector_core #(
    parameter int NUM_CPUS      = 4,
    parameter int HISTORY_DEPTH = 4,
    parameter int ADDR_BITS     = 48
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Bits from low up: cpu_id (2), address (ADDR_BITS), ordering (3), zero padding.
    input  logic [((iwrd_pkg::CPU_ID_W + ADDR_BITS + iwrd_pkg::ORDER_W + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,
    // Bits from low up: mode (2).
    input  iwrd_pkg::mode_t s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // Bits from low up: race_found (1), zero padding.
    output logic [7:0] m_axis_tdata
);
    import iwrd_pkg::*;

    localparam int ADDR_LSB  = CPU_ID_W;
    localparam int ORDER_LSB = CPU_ID_W + ADDR_BITS;

    // Input stage.
    logic                 s1_valid_reg;
    mode_t                s1_mode_reg;
    cpu_id_t              s1_cpu_reg;
    logic [ADDR_BITS-1:0] s1_addr_reg;
    order_t               s1_order_reg;

    // Per-CPU write history, slot 0 newest.
    logic [ADDR_BITS-1:0] hist_addr_reg  [NUM_CPUS][HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hist_valid_reg [NUM_CPUS];

    // Result stage.
    logic m_valid_reg;
    logic m_race_reg;

    logic advance;
    logic s1_fire;
    logic race_next;
    logic [NUM_CPUS-1:0] cpu_sel;

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && advance;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_race_reg};

    always_comb begin
        race_next = 1'b0;
        for (int c = 0; c < NUM_CPUS; c++) begin
            cpu_sel[c] = (32'(s1_cpu_reg) == c);
            for (int s = 0; s < HISTORY_DEPTH; s++) begin
                if (hist_valid_reg[c][s] && (hist_addr_reg[c][s] == s1_addr_reg)) begin
                    race_next = 1'b1;
                end
            end
        end
        if (s1_mode_reg != MODE_READ) begin
            race_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            s1_mode_reg  <= s_axis_tuser;
            s1_cpu_reg   <= s_axis_tdata[CPU_ID_W-1:0];
            s1_addr_reg  <= s_axis_tdata[ADDR_LSB +: ADDR_BITS];
            s1_order_reg <= s_axis_tdata[ORDER_LSB +: ORDER_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_race_reg <= race_next;
        end
    end

    // Valid bits: a write begin shifts in a live entry, a write end an empty one,
    // and a release-type fence empties the issuing CPU's history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CPUS; c++) begin
                hist_valid_reg[c] <= '0;
            end
        end else if (s1_fire) begin
            for (int c = 0; c < NUM_CPUS; c++) begin
                if (cpu_sel[c]) begin
                    unique case (s1_mode_reg)
                        MODE_WRITE_BEGIN: begin
                            hist_valid_reg[c] <= (hist_valid_reg[c] << 1) | HISTORY_DEPTH'(1);
                        end
                        MODE_WRITE_END: begin
                            hist_valid_reg[c] <= hist_valid_reg[c] << 1;
                        end
                        MODE_FENCE: begin
                            if (is_release(s1_order_reg)) begin
                                hist_valid_reg[c] <= '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            for (int c = 0; c < NUM_CPUS; c++) begin
                if (cpu_sel[c] && ((s1_mode_reg == MODE_WRITE_BEGIN) ||
                                   (s1_mode_reg == MODE_WRITE_END))) begin
                    for (int s = HISTORY_DEPTH - 1; s > 0; s--) begin
                        hist_addr_reg[c][s] <= hist_addr_reg[c][s-1];
                    end
                    hist_addr_reg[c][0] <= (s1_mode_reg == MODE_WRITE_BEGIN) ?
                                           s1_addr_reg : '0;
                end
            end
        end
    end

    `ASSERT_CLK(a_race_only_on_read, aclk, aresetn,
        (s1_fire && (s1_mode_reg != MODE_READ)) |=> !m_race_reg,
        "race flagged for an event that is not a read")
    `ASSERT_CLK(a_stage1_holds, aclk, aresetn,
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_addr_reg) && $stable(s1_mode_reg)),
        "input stage lost or changed a stalled event")
    `ASSERT_ALWAYS(a_reset_empties, aclk,
        !aresetn |=> (hist_valid_reg[0] == '0),
        "history not emptied by reset")

endmodule
